[hw/rtl/fqd_pkg.sv]
// fqd_pkg: shared types and constants for the FIFO queue with delete.
// Used by fqd_cell, fqd_ctrl and fifo_queue_with_delete; no dependencies.
package fqd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_DEQUEUE = 2'd1;
  localparam logic [1:0] MODE_DELETE  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] count;
  } out_word_t;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_ALL,
    CELL_SHIFT_HIT,
    CELL_SCAN
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } fqd_state_t;

endpackage

[hw/rtl/fqd_cell.sv]
// fqd_cell: one storage slot of the queue chain, with its match-ripple flag.
// Depends on fqd_pkg (cell_op_t).
module fqd_cell #(
  parameter int DATA_WIDTH = fqd_pkg::DATA_WIDTH_DEF,
  parameter int OW         = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fqd_pkg::cell_op_t     cell_op,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [OW-1:0]         occ,
  input  logic [DATA_WIDTH-1:0] nbr_data,
  input  logic                  prev_hit,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  hit
);

  logic [DATA_WIDTH-1:0] data_r;
  logic                  hit_r;
  logic                  live;
  logic                  match;

  assign live  = (OW'(IDX) < occ);
  assign match = live && (data_r == word);

  always_ff @(posedge clk) begin
    case (cell_op)
      fqd_pkg::CELL_WRITE: begin
        if (occ == OW'(IDX)) begin
          data_r <= word;
        end
      end
      fqd_pkg::CELL_SHIFT_ALL: begin
        data_r <= nbr_data;
      end
      fqd_pkg::CELL_SHIFT_HIT: begin
        // slots at or after the oldest match pull from the right
        if (hit_r) begin
          data_r <= nbr_data;
        end
      end
      default: begin
      end
    endcase
  end

  // prefix-OR of matches, one cell further each scan cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cell_op == fqd_pkg::CELL_SCAN) begin
      hit_r <= match | prev_hit;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

[hw/rtl/fqd_ctrl.sv]
// fqd_ctrl: sequencer, occupancy count, scan counter and output register.
// Depends on fqd_pkg (words, codes, state and cell command types).
module fqd_ctrl #(
  parameter int DEPTH      = fqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqd_pkg::DATA_WIDTH_DEF,
  localparam int OW        = $clog2(DEPTH + 1),
  localparam int SW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fqd_pkg::in_word_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fqd_pkg::out_word_t    out_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  input  logic                  found,
  output fqd_pkg::cell_op_t     cell_op,
  output logic [DATA_WIDTH-1:0] cell_word,
  output logic [OW-1:0]         occ
);

  fqd_pkg::fqd_state_t state_r, state_nxt;
  logic [OW-1:0]                occ_r, occ_nxt;
  logic [SW-1:0]                step_r, step_nxt;
  logic [DATA_WIDTH-1:0]        word_r, word_nxt;
  logic                         res_status_r, res_status_nxt;
  logic [fqd_pkg::VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                         out_valid_r;
  fqd_pkg::out_word_t           out_data_r;
  logic                         out_free;
  logic                         out_load;
  logic [DATA_WIDTH-1:0]        in_word;
  logic [DATA_WIDTH+fqd_pkg::VALUE_W-1:0] in_ext;
  logic [DATA_WIDTH+fqd_pkg::VALUE_W-1:0] head_ext;
  logic [OW+fqd_pkg::COUNT_W-1:0]         occ_ext;

  // fit the 32-bit value field to the stored word width and back
  assign in_ext   = {{DATA_WIDTH{1'b0}}, in_data.value};
  assign in_word  = in_ext[DATA_WIDTH-1:0];
  assign head_ext = {{fqd_pkg::VALUE_W{1'b0}}, head_data};
  assign occ_ext  = {{fqd_pkg::COUNT_W{1'b0}}, occ_r};

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == fqd_pkg::ST_IDLE);
  assign cell_word = (state_r == fqd_pkg::ST_IDLE) ? in_word : word_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fqd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.mode == fqd_pkg::MODE_DELETE) && (in_word != '0)) begin
            state_nxt = fqd_pkg::ST_SCAN;
          end else begin
            state_nxt = fqd_pkg::ST_DONE;
          end
        end
      end
      fqd_pkg::ST_SCAN: begin
        if (step_r == SW'(DEPTH - 1)) begin
          state_nxt = fqd_pkg::ST_APPLY;
        end
      end
      fqd_pkg::ST_APPLY: begin
        state_nxt = fqd_pkg::ST_DONE;
      end
      fqd_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fqd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    cell_op        = fqd_pkg::CELL_HOLD;
    occ_nxt        = occ_r;
    step_nxt       = step_r;
    word_nxt       = word_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_load       = 1'b0;
    case (state_r)
      fqd_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = fqd_pkg::STATUS_FAIL;
          res_value_nxt  = '0;
          word_nxt       = in_word;
          step_nxt       = '0;
          case (in_data.mode)
            fqd_pkg::MODE_ENQUEUE: begin
              if (occ_r < OW'(DEPTH)) begin
                cell_op        = fqd_pkg::CELL_WRITE;
                occ_nxt        = occ_r + OW'(1);
                res_status_nxt = fqd_pkg::STATUS_OK;
              end
            end
            fqd_pkg::MODE_DEQUEUE: begin
              if (occ_r != '0) begin
                cell_op        = fqd_pkg::CELL_SHIFT_ALL;
                occ_nxt        = occ_r - OW'(1);
                res_status_nxt = fqd_pkg::STATUS_OK;
                res_value_nxt  = head_ext[fqd_pkg::VALUE_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      fqd_pkg::ST_SCAN: begin
        cell_op  = fqd_pkg::CELL_SCAN;
        step_nxt = step_r + SW'(1);
      end
      fqd_pkg::ST_APPLY: begin
        if (found) begin
          cell_op        = fqd_pkg::CELL_SHIFT_HIT;
          occ_nxt        = occ_r - OW'(1);
          res_status_nxt = fqd_pkg::STATUS_OK;
        end
      end
      fqd_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqd_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (out_load) begin
      out_data_r.status    <= res_status_r;
      out_data_r.value_out <= res_value_r;
      out_data_r.count     <= occ_ext[fqd_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign occ       = occ_r;

endmodule

[hw/rtl/fifo_queue_with_delete.sv]
// fifo_queue_with_delete: bounded FIFO of words with dequeue and delete-by-value.
// Built from fqd_ctrl and a chain of DEPTH fqd_cell slots; depends on fqd_pkg.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_ready   | fqd_pkg::in_word_t  (mode, value)
//   out_    | output    | out_valid / out_ready | fqd_pkg::out_word_t (status, value_out, count)
//
// Sequence: enqueue, dequeue, zero-word delete and the unused mode go from accept
// (ST_IDLE) straight to result (ST_DONE). A nonzero-word delete, hit or miss, runs
// ST_SCAN then ST_APPLY first; the match flag ripples one slot per cycle along the cell chain.
// Reset: occupancy and control clear at once; slot contents are not cleared.
// Stalls: a finished result waits in the output register while the next word
// is accepted; a second result waits in the control block until out_ready.
module fifo_queue_with_delete #(
  parameter int DEPTH      = fqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqd_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fqd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fqd_pkg::out_word_t out_data
);

  localparam int OW = $clog2(DEPTH + 1);

  fqd_pkg::cell_op_t     cell_op;
  logic [DATA_WIDTH-1:0] cell_word;
  logic [OW-1:0]         occ;
  logic [DATA_WIDTH-1:0] slot_data [DEPTH];
  logic                  slot_hit  [DEPTH];

  fqd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head_data (slot_data[0]),
    .found     (slot_hit[DEPTH-1]),
    .cell_op   (cell_op),
    .cell_word (cell_word),
    .occ       (occ)
  );

  // slot 0 holds the oldest word; shifts move words toward slot 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    logic                  prev;
    if (i == DEPTH - 1) begin : g_last
      // past the tail: content is dead after the shift
      assign nbr = slot_data[i];
    end else begin : g_mid
      assign nbr = slot_data[i+1];
    end
    if (i == 0) begin : g_first
      assign prev = 1'b0;
    end else begin : g_rest
      assign prev = slot_hit[i-1];
    end

    fqd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .OW         (OW),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_op  (cell_op),
      .word     (cell_word),
      .occ      (occ),
      .nbr_data (nbr),
      .prev_hit (prev),
      .data     (slot_data[i]),
      .hit      (slot_hit[i])
    );
  end

`ifndef ASSERT_OFF
  // occupancy never exceeds the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OW'(DEPTH))
    else $error("occupancy above DEPTH");

  // a delete of a nonzero word blocks input for the scan
  a_del_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.mode == fqd_pkg::MODE_DELETE) &&
     (in_data.value != '0)) |=> !in_ready)
    else $error("input accepted during delete scan");

  // a failed operation reports a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == fqd_pkg::STATUS_FAIL)) |-> (out_data.value_out == '0))
    else $error("failed result carries data");

  // occupancy moves by at most one per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((occ == $past(occ)) || (occ == $past(occ) + OW'(1)) ||
                      (occ + OW'(1) == $past(occ))))
    else $error("occupancy jumped");
`endif

endmodule
